### rtl/ipv4rf_pkg.sv
// ----------------------------------------------------------------------------
// ipv4rf_pkg
// Shared types, codes and helpers of the IPv4 receive header filter.
// ----------------------------------------------------------------------------
package ipv4rf_pkg;

  // header field constants
  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [31:0] BROADCAST_ADDR = 32'hffff_ffff;
  localparam logic [15:0] SUM_GOOD       = 16'hffff;

  // protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // header word positions (counted from the first word as zero)
  localparam logic [4:0] WORD_FLAGS    = 5'd3;
  localparam logic [4:0] WORD_PROTOCOL = 5'd4;
  localparam logic [4:0] WORD_DEST_HI  = 5'd8;
  localparam logic [4:0] WORD_DEST_LO  = 5'd9;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_ADDRESS      = 2'd0;
  localparam logic [1:0] CFG_TCP_ENABLE       = 2'd1;
  localparam logic [1:0] CFG_MIN_FRAME_LENGTH = 2'd2;

  localparam logic [15:0] MIN_FRAME_LENGTH_RESET = 16'd34;

  typedef enum logic [1:0] {
    VERDICT_DROP = 2'd0,
    VERDICT_ICMP = 2'd1,
    VERDICT_UDP  = 2'd2,
    VERDICT_TCP  = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_VER_IHL  = 3'd1,
    REASON_SHORT    = 3'd2,
    REASON_ADDRESS  = 3'd3,
    REASON_FRAGMENT = 3'd4,
    REASON_CHECKSUM = 3'd5,
    REASON_PROTOCOL = 3'd6
  } reason_t;

  // classified packet handed from the front to the back
  typedef struct packed {
    logic        early;         // dropped on the first word
    reason_t     early_reason;
    logic [31:0] destination;
    logic        more_fragments;
    logic        sum_ok;
    logic [7:0]  protocol;
  } job_t;

  // ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### rtl/ipv4rf_front.sv
// ----------------------------------------------------------------------------
// ipv4rf_front
// Accepts header words, tracks the header and classifies each packet.
// ----------------------------------------------------------------------------
module ipv4rf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                word_fire,
  input  logic [15:0]         header_word,
  input  logic                first_word,
  input  logic [15:0]         frame_length,
  input  logic [15:0]         min_frame_length,
  output logic                job_valid,
  output ipv4rf_pkg::job_t    job
);

  logic        collecting_r, collecting_nxt;
  logic [4:0]  word_count_r, word_count_nxt;
  logic [4:0]  header_words_r, header_words_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  protocol_r, protocol_nxt;
  logic [31:0] dest_r, dest_nxt;
  logic        mf_r, mf_nxt;

  logic [3:0]  version;
  logic [3:0]  ihl;

  assign version = header_word[15:12];
  assign ihl     = header_word[11:8];

  // header tracking and classification
  always_comb begin
    collecting_nxt   = collecting_r;
    word_count_nxt   = word_count_r;
    header_words_nxt = header_words_r;
    sum_nxt          = sum_r;
    protocol_nxt     = protocol_r;
    dest_nxt         = dest_r;
    mf_nxt           = mf_r;
    job_valid        = 1'b0;
    job              = '0;
    job.early_reason = ipv4rf_pkg::REASON_NONE;

    if (word_fire && first_word) begin
      collecting_nxt = 1'b0;
      if (version != ipv4rf_pkg::IP_VERSION || ihl < ipv4rf_pkg::MIN_IHL) begin
        job_valid        = 1'b1;
        job.early        = 1'b1;
        job.early_reason = ipv4rf_pkg::REASON_VER_IHL;
      end else if (frame_length < min_frame_length) begin
        job_valid        = 1'b1;
        job.early        = 1'b1;
        job.early_reason = ipv4rf_pkg::REASON_SHORT;
      end else begin
        header_words_nxt = {ihl, 1'b0};
        word_count_nxt   = 5'd1;
        sum_nxt          = header_word;
        protocol_nxt     = '0;
        dest_nxt         = '0;
        mf_nxt           = 1'b0;
        collecting_nxt   = 1'b1;
      end
    end else if (word_fire && collecting_r) begin
      sum_nxt = ipv4rf_pkg::oc_add(sum_r, header_word);
      if (word_count_r == ipv4rf_pkg::WORD_FLAGS) begin
        mf_nxt = header_word[13];
      end else if (word_count_r == ipv4rf_pkg::WORD_PROTOCOL) begin
        protocol_nxt = header_word[7:0];
      end else if (word_count_r == ipv4rf_pkg::WORD_DEST_HI) begin
        dest_nxt = {header_word, dest_r[15:0]};
      end else if (word_count_r == ipv4rf_pkg::WORD_DEST_LO) begin
        dest_nxt = {dest_r[31:16], header_word};
      end
      word_count_nxt = word_count_r + 5'd1;
      // last header word: hand the packet to the back
      if (word_count_nxt == header_words_r) begin
        collecting_nxt     = 1'b0;
        job_valid          = 1'b1;
        job.early          = 1'b0;
        job.destination    = dest_nxt;
        job.more_fragments = mf_nxt;
        job.sum_ok         = (sum_nxt == ipv4rf_pkg::SUM_GOOD);
        job.protocol       = protocol_nxt;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
    end else begin
      collecting_r <= collecting_nxt;
    end
  end

  // header fields
  always_ff @(posedge clk) begin
    word_count_r   <= word_count_nxt;
    header_words_r <= header_words_nxt;
    sum_r          <= sum_nxt;
    protocol_r     <= protocol_nxt;
    dest_r         <= dest_nxt;
    mf_r           <= mf_nxt;
  end

endmodule

### rtl/ipv4rf_queue.sv
// ----------------------------------------------------------------------------
// ipv4rf_queue
// Short first-in first-out queue of classified packets between front and back.
// ----------------------------------------------------------------------------
module ipv4rf_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ipv4rf_pkg::job_t push_job,
  input  logic             pop,
  output logic             head_valid,
  output ipv4rf_pkg::job_t head_job,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipv4rf_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/ipv4rf_back.sv
// ----------------------------------------------------------------------------
// ipv4rf_back
// Runs the address, fragment, checksum and protocol checks and holds the result.
// ----------------------------------------------------------------------------
module ipv4rf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  ipv4rf_pkg::job_t     head_job,
  output logic                 pop,
  input  logic [31:0]          own_address,
  input  logic                 tcp_enable,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ipv4rf_pkg::verdict_t out_verdict,
  output ipv4rf_pkg::reason_t  out_reason
);

  logic                 valid_r;
  ipv4rf_pkg::verdict_t verdict_r, verdict_nxt;
  ipv4rf_pkg::reason_t  reason_r, reason_nxt;

  assign pop         = head_valid && (!valid_r || out_ready);
  assign out_valid   = valid_r;
  assign out_verdict = verdict_r;
  assign out_reason  = reason_r;

  // checks in priority order
  always_comb begin
    verdict_nxt = ipv4rf_pkg::VERDICT_DROP;
    reason_nxt  = ipv4rf_pkg::REASON_NONE;
    priority if (head_job.early) begin
      reason_nxt = head_job.early_reason;
    end else if (head_job.destination != ipv4rf_pkg::BROADCAST_ADDR &&
                 head_job.destination != own_address) begin
      reason_nxt = ipv4rf_pkg::REASON_ADDRESS;
    end else if (head_job.more_fragments) begin
      reason_nxt = ipv4rf_pkg::REASON_FRAGMENT;
    end else if (!head_job.sum_ok) begin
      reason_nxt = ipv4rf_pkg::REASON_CHECKSUM;
    end else if (head_job.protocol == ipv4rf_pkg::PROTO_ICMP) begin
      verdict_nxt = ipv4rf_pkg::VERDICT_ICMP;
    end else if (head_job.protocol == ipv4rf_pkg::PROTO_UDP) begin
      verdict_nxt = ipv4rf_pkg::VERDICT_UDP;
    end else if (head_job.protocol == ipv4rf_pkg::PROTO_TCP && tcp_enable) begin
      verdict_nxt = ipv4rf_pkg::VERDICT_TCP;
    end else begin
      reason_nxt = ipv4rf_pkg::REASON_PROTOCOL;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r <= verdict_nxt;
      reason_r  <= reason_nxt;
    end
  end

endmodule

### rtl/ipv4_receive_header_filter.sv
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter
// Checks received IPv4 headers word by word and gives one verdict per packet.
// ----------------------------------------------------------------------------
// The block takes one 16-bit header word per cycle and gives one verdict per
// packet. The front tracks the header as it streams in and classifies the
// packet on its first word (bad version/ihl, short frame) or on its last
// header word; the back runs the address, fragment, checksum and protocol
// checks and holds the verdict in an output register. A queue of QUEUE_DEPTH
// entries sits between them, so in_tready only falls when the queue is full,
// which needs the result side to stall. Words outside a header give no result.
module ipv4_receive_header_filter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] header_word, [31:16] frame_length
  input  logic        in_tuser,   // [0] first_word
  // verdicts
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] verdict, [4:2] drop_reason, [7:5] zero
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] own_address_r;
  logic        tcp_enable_r;
  logic [15:0] min_frame_length_r;

  logic                 word_fire;
  logic                 job_valid;
  ipv4rf_pkg::job_t     job;
  logic                 head_valid;
  ipv4rf_pkg::job_t     head_job;
  logic                 pop;
  logic                 queue_full;
  ipv4rf_pkg::verdict_t verdict;
  ipv4rf_pkg::reason_t  reason;

  assign in_tready = !queue_full;
  assign word_fire = in_tvalid && in_tready;
  assign out_tdata = {3'b000, reason, verdict};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r      <= '0;
      tcp_enable_r       <= 1'b0;
      min_frame_length_r <= ipv4rf_pkg::MIN_FRAME_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ipv4rf_pkg::CFG_OWN_ADDRESS:      own_address_r      <= cfg_wdata;
        ipv4rf_pkg::CFG_TCP_ENABLE:       tcp_enable_r       <= cfg_wdata[0];
        ipv4rf_pkg::CFG_MIN_FRAME_LENGTH: min_frame_length_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  ipv4rf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .word_fire        (word_fire),
    .header_word      (in_tdata[15:0]),
    .first_word       (in_tuser),
    .frame_length     (in_tdata[31:16]),
    .min_frame_length (min_frame_length_r),
    .job_valid        (job_valid),
    .job              (job)
  );

  ipv4rf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_valid),
    .push_job   (job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (queue_full)
  );

  ipv4rf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .own_address (own_address_r),
    .tcp_enable  (tcp_enable_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_verdict (verdict),
    .out_reason  (reason)
  );

endmodule
